### src/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_MOVE = 2'b10
   } state_type;

   typedef struct packed {
      logic capture;
      logic valid;
      logic shift;
   } cell_ctrl_type;

endpackage

### src/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: request control, cell chain and result register.
//
// A fully associative cache of CAPACITY entries held in a chain of cells ordered from most
// to least recent. Each request has two steps: in the cycle of its transfer every valid
// cell compares its key with a lookup key, and then, in the reorder state, the hit entry
// (or the new entry on an insert) moves to the front while the cells ahead shift back
// by one. A new request is taken only after the reorder of the last one completes; a held
// result delays the reorder cycle, and the input stays stalled until it completes. Inserts
// never check for duplicates; a full cache drops its least recent entry. No clearing pass is
// needed after reset.
module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0]        req_value_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic [VAL_W-1:0]        rsp_value_out
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   op_type           op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   logic [KEY_W-1:0] cell_key [CAPACITY+1];
   logic [VAL_W-1:0] cell_value [CAPACITY+1];
   logic [CAPACITY-1:0] match, first, above;
   cell_ctrl_type    ctrl [CAPACITY];

   logic             accept, rsp_free, move_go, hit_any;
   logic [VAL_W-1:0] hit_value;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign move_go   = (state_ff == ST_MOVE) && rsp_free;
   assign hit_any   = |match;

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_value = hit_value | (first[i] ? cell_value[i+1] : '0);
      end
   end

   assign cell_key[0]   = key_ff;
   assign cell_value[0] = (op_ff == OP_INSERT) ? val_ff : hit_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_front
         assign above[i] = 1'b0;
      end else begin : g_rest
         assign above[i] = |match[i-1:0];
      end
      assign first[i] = match[i] && !above[i];

      assign ctrl[i].capture = accept;
      assign ctrl[i].valid   = (CNT_W'(i) < count_ff) && (req_opcode == OP_LOOKUP);
      assign ctrl[i].shift   = move_go && ((op_ff == OP_INSERT) || (hit_any && !above[i]));

      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl[i]),
         .cmp_key    (req_key),
         .prev_key   (cell_key[i]),
         .prev_value (cell_value[i]),
         .key_out    (cell_key[i+1]),
         .value_out  (cell_value[i+1]),
         .match      (match[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (move_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (move_go && (op_ff == OP_INSERT) && (count_ff < CNT_W'(CAPACITY))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (move_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_opcode);
         key_ff <= req_key;
         val_ff <= req_value_in;
      end
      if (move_go) begin
         rsp_hit_ff   <= hit_any;
         rsp_value_ff <= hit_value;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_value_out = rsp_value_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MOVE))
      else $error("accepted request did not enter the reorder cycle");

   a_insert_no_hit: assert property (@(posedge clock) disable iff (reset)
      (move_go && (op_ff == OP_INSERT)) |=> (rsp_valid && !rsp_hit && (rsp_value_out == '0)))
      else $error("insert produced a hit result");
`endif

endmodule

### src/lkvc_cell.sv
// One recency position of the cache: stored entry, key compare and shift from the neighbor.
module lkvc_cell
   import lkvc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [KEY_W-1:0]   cmp_key,
   input  logic [KEY_W-1:0]   prev_key,
   input  logic [VAL_W-1:0]   prev_value,
   output logic [KEY_W-1:0]   key_out,
   output logic [VAL_W-1:0]   value_out,
   output logic               match
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             match_ff, match_in;

   always_comb begin
      key_in   = ctrl.shift ? prev_key : key_ff;
      value_in = ctrl.shift ? prev_value : value_ff;
      match_in = ctrl.capture ? (ctrl.valid && (key_ff == cmp_key)) : match_ff;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign match     = match_ff;

endmodule

### bench/tb.sv
// Self-checking testbench for the LRU key-value cache with its own recency-order predictor.
module tb;
   import lkvc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = CAPACITY_DEF;
   localparam int HOLD_CYCLES = 200;
   localparam int POOL_SIZE = 32;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] value;
   } lookup_result_type;

   class cache_scoreboard;
      logic [KEY_W-1:0]  slot_key [DEPTH];
      logic [VAL_W-1:0]  slot_value [DEPTH];
      int                rank [DEPTH];
      int                live;
      lookup_result_type awaited [$];
      int                mismatches;

      function new();
         foreach (rank[i]) begin
            rank[i] = i;
            slot_key[i] = '0;
            slot_value[i] = '0;
         end
         live = 0;
         mismatches = 0;
      endfunction

      function int move_to_front(int pos);
         int slot;
         slot = rank[pos];
         for (int i = pos; i > 0; i--) begin
            rank[i] = rank[i-1];
         end
         rank[0] = slot;
         return slot;
      endfunction

      function void record_request(op_type op, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] data);
         lookup_result_type outcome;
         int slot;
         outcome = '0;
         if (op == OP_INSERT) begin
            slot = move_to_front((live < DEPTH) ? live : DEPTH - 1);
            slot_key[slot] = key;
            slot_value[slot] = data;
            if (live < DEPTH) begin
               live++;
            end
         end else begin
            for (int i = 0; i < live && !outcome.hit; i++) begin
               if (slot_key[rank[i]] == key) begin
                  outcome.hit = 1'b1;
                  outcome.value = slot_value[rank[i]];
                  void'(move_to_front(i));
               end
            end
         end
         awaited.push_back(outcome);
      endfunction

      task report(string msg);
         if (mismatches < 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
         mismatches++;
      endtask

      task check_response(logic hit, logic [VAL_W-1:0] data);
         lookup_result_type want;
         if (awaited.size() == 0) begin
            report("response transfer with no request outstanding");
            return;
         end
         want = awaited.pop_front();
         if (hit !== want.hit) begin
            report($sformatf("hit got %b expected %b", hit, want.hit));
         end
         if (data !== want.value) begin
            report($sformatf("value_out got %h expected %h", data, want.value));
         end
      endtask

      function int pending_count();
         return awaited.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_opcode;
   logic signed [KEY_W-1:0] req_key;
   logic [VAL_W-1:0]        req_value_in;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_hit;
   logic [VAL_W-1:0]        rsp_value_out;

   cache_scoreboard  board;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int               req_idle_pct = 37;
   int               rsp_idle_pct = 37;
   int               hold_requests = 0;

   lru_key_value_cache_unit #(
      .CAPACITY(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .req_value_in(req_value_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_value_out(rsp_value_out)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_request(op_type op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_key <= key;
      req_value_in <= data;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      board.record_request(op, key, data);
   endtask

   task automatic send_random(int span);
      op_type           op;
      logic [KEY_W-1:0] key;
      op = ($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP;
      if ($urandom_range(99) < 75) begin
         key = key_pool[$urandom_range(span - 1)];
      end else begin
         key = $urandom;
      end
      send_request(op, key, $urandom);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending_count() > 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         board.check_response(rsp_hit, rsp_value_out);
      end
   end

   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      board = new();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'hFFFF_FFFF;
      key_pool[3] = 32'h0000_0000;
      for (int i = 4; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_LOOKUP;
      req_key <= '0;
      req_value_in <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty cache, extreme keys and values, a duplicate key, then overflow and eviction.
      send_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
      send_request(OP_INSERT, 32'h0000_0000, 32'h5A5A_5A5A);
      send_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
      send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h1111_1111);
      send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      for (int i = 0; i < 13; i++) begin
         send_request(OP_INSERT, 32'h0000_0100 + i, $urandom);
      end
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);

      repeat (500) send_random(24);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (300) send_random(8);

      hold_requests++;
      repeat (40) send_random(24);
      drain_results();

      req_idle_pct = 37;
      rsp_idle_pct = 37;
      repeat (440) send_random(POOL_SIZE);

      drain_results();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

### lru_key_value_cache_unit.f
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache_unit.sv
bench/tb.sv
